// File: sv/fla_pkg.sv
`default_nettype none

package fla_pkg;

    // Default heap depth in 16-byte units
    localparam int unsigned HEAP_UNITS_DEFAULT = 65536;

    localparam int LINK_W    = 16;
    localparam int SIZE_W    = 17;
    localparam int BYTES_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int UNIT_SHIFT = 4;

    localparam logic [SIZE_W-1:0] HEAP_LIMIT_RESET = SIZE_W'(65536);
    localparam logic [SIZE_W-1:0] GROW_MIN_RESET   = SIZE_W'(4096);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_MIN   = CFG_IDX_W'(1);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // One block header: next link and size in units
    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    // Header write request, one header index per cycle
    typedef struct packed {
        logic              link_we;
        logic              size_we;
        logic [LINK_W-1:0] idx;
        logic [LINK_W-1:0] link;
        logic [SIZE_W-1:0] size;
    } hdr_wr_t;

endpackage

`default_nettype wire

// File: sv/fla_chan_if.sv
`default_nettype none

// Request channel: allocate or free
interface fla_req_if import fla_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [BYTES_W-1:0] request_bytes;
    logic [LINK_W-1:0]  free_address;

    modport source (output valid, output operation, output request_bytes,
                    output free_address, input ready);
    modport sink   (input valid, input operation, input request_bytes,
                    input free_address, output ready);
endinterface

// Response channel: one result per request
interface fla_rsp_if import fla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LINK_W-1:0] block_address;
    logic              status;

    modport source (output valid, output block_address, output status, input ready);
    modport sink   (input valid, input block_address, input status, output ready);
endinterface

// Configuration write channel
interface fla_cfg_if import fla_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/free_list_heap_allocator.sv
// Channel | Dir | Payload                                   | Transfer
// req     | in  | operation, request_bytes, free_address    | valid & ready
// rsp     | out | block_address, status                     | valid & ready
// cfg     | in  | index (0 heap_limit_units, 1 grow_min_units), data | valid & ready
//
// Steps (transfer to result valid): allocate reads the rover header and tests
//   each free-list node visited, plus a tail carve; each heap growth moves the
//   break and walks nodes to insert the new region, plus an upper merge. Free
//   walks nodes to its insert point, plus an upper merge. An ignored free or an
//   oversized request skips the walk. Every node visited is one header-store read.
// Reset: control state only. Headers are never cleared; the sentinel at
//   unit 0 is written by the first allocate. No clearing pass.
// Stalls: one request in flight; req.ready and cfg.ready are high only when
//   idle. The result waits in the response register while the next request
//   is taken.
`default_nettype none

module free_list_heap_allocator
    import fla_pkg::*;
#(
    parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    fla_req_if.sink   req,
    fla_rsp_if.source rsp,
    fla_cfg_if.sink   cfg
);

    // Walk bound: a corrupted list may loop forever
    localparam int unsigned WALK_CAP = 4 * HEAP_UNITS + 8;
    localparam int STEP_W = $clog2(WALK_CAP + 2);
    // Highest break value: heap depth, and 16-bit payload indexes
    localparam logic [SIZE_W-1:0] LIMIT_CAP =
        SIZE_W'((HEAP_UNITS < 65535) ? HEAP_UNITS : 65535);
    // Units needed fit this many bits for any 32-bit byte count
    localparam int NEED_W = BYTES_W - UNIT_SHIFT + 1;
    localparam logic [BYTES_W:0] UNIT_ROUND = (BYTES_W + 1)'((1 << UNIT_SHIFT) - 1);
    localparam logic [NEED_W-1:0] MAX_NEED = NEED_W'((1 << LINK_W) - 1);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_RD_ROVER = 12'b0000_0000_0010,  // read rover header
        ST_A_FIRST  = 12'b0000_0000_0100,  // p = link(rover)
        ST_A_CHK    = 12'b0000_0000_1000,  // next-fit test of p
        ST_A_CARVE  = 12'b0000_0001_0000,  // write tail header
        ST_A_GROW   = 12'b0000_0010_0000,  // move break
        ST_I_CHK    = 12'b0000_0100_0000,  // insert walk
        ST_I_HDR    = 12'b0000_1000_0000,  // size of new block
        ST_I_NEXT   = 12'b0001_0000_0000,  // merge with upper neighbor
        ST_I_PDAT   = 12'b0010_0000_0000,  // size of lower neighbor
        ST_I_LINK   = 12'b0100_0000_0000,  // merge or link lower neighbor
        ST_OUT      = 12'b1000_0000_0000   // hand result to rsp register
    } state_t;

    state_t state_reg, state_next;

    // Allocator state
    logic [LINK_W-1:0] rover_reg, rover_next;
    logic              started_reg, started_next;
    logic [SIZE_W-1:0] break_reg, break_next;
    logic [SIZE_W-1:0] limit_reg, limit_next;
    logic [SIZE_W-1:0] grow_min_reg, grow_min_next;

    // Walk registers
    logic [LINK_W-1:0] p_reg, p_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] hdr_reg, hdr_next;
    logic [LINK_W-1:0] q_reg, q_next;
    logic [LINK_W-1:0] need_reg, need_next;
    logic [SIZE_W-1:0] grow_reg, grow_next;
    logic [SIZE_W-1:0] sh_reg, sh_next;
    logic [SIZE_W-1:0] sp_reg, sp_next;
    logic [SIZE_W-1:0] rest_reg, rest_next;
    logic              alloc_mode_reg, alloc_mode_next;
    logic [STEP_W-1:0] a_steps_reg, a_steps_next;
    logic [STEP_W-1:0] i_steps_reg, i_steps_next;

    // Result and response registers
    logic [LINK_W-1:0] res_addr_reg, res_addr_next;
    logic              res_status_reg, res_status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [LINK_W-1:0] rsp_addr_reg, rsp_addr_next;
    logic              rsp_status_reg, rsp_status_next;

    // Header store port
    logic [LINK_W-1:0] rd_idx;
    hdr_wr_t           hdr_wr;
    hdr_t              rd_hdr;

    logic              req_xfer;
    logic [NEED_W-1:0] need_full;
    logic [SIZE_W-1:0] limit_now;
    logic              ins_found;
    logic [LINK_W-1:0] carve_p;
    logic [LINK_W-1:0] carve_addr;
    logic [LINK_W-1:0] fit_addr;
    logic [SIZE_W:0]   grow_sum;

    fla_hdr_store #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_hdr_store (
        .clk    (clk),
        .rd_idx (rd_idx),
        .wr     (hdr_wr),
        .rd_hdr (rd_hdr)
    );

    assign req_xfer  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = (state_reg == ST_IDLE);

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.block_address = rsp_addr_reg;
    assign rsp.status        = rsp_status_reg;

    // Round bytes up to units, plus the header unit
    assign need_full = NEED_W'(({1'b0, req.request_bytes} + UNIT_ROUND) >> UNIT_SHIFT)
                       + NEED_W'(1);

    assign limit_now = (limit_reg < LIMIT_CAP) ? limit_reg : LIMIT_CAP;

    // Insert point: hdr between p and q, or past the wrap of the ring
    assign ins_found = ((hdr_reg > p_reg) && (hdr_reg < rd_hdr.link)) ||
                       ((p_reg >= rd_hdr.link) &&
                        ((hdr_reg > p_reg) || (hdr_reg < rd_hdr.link)));

    // Tail carve: new header sits rest units above p
    assign carve_p    = p_reg + rest_reg[LINK_W-1:0];
    assign carve_addr = carve_p + LINK_W'(1);
    assign fit_addr   = p_reg + LINK_W'(1);

    assign grow_sum = {1'b0, break_reg} + {1'b0, grow_reg};

    always_comb
    begin
        state_next      = state_reg;
        rover_next      = rover_reg;
        started_next    = started_reg;
        break_next      = break_reg;
        limit_next      = limit_reg;
        grow_min_next   = grow_min_reg;
        p_next          = p_reg;
        prev_next       = prev_reg;
        hdr_next        = hdr_reg;
        q_next          = q_reg;
        need_next       = need_reg;
        grow_next       = grow_reg;
        sh_next         = sh_reg;
        sp_next         = sp_reg;
        rest_next       = rest_reg;
        alloc_mode_next = alloc_mode_reg;
        a_steps_next    = a_steps_reg;
        i_steps_next    = i_steps_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        rd_idx          = rover_reg;
        hdr_wr          = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Config writes only land while idle
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_HEAP_LIMIT: limit_next    = cfg.data;
                CFG_GROW_MIN:   grow_min_next = cfg.data;
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        alloc_mode_next = 1'b1;
                        need_next       = need_full[LINK_W-1:0];
                        a_steps_next    = '0;
                        if (need_full > MAX_NEED)
                        begin
                            res_addr_next   = '0;
                            res_status_next = STAT_FAIL;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            if (!started_reg)
                            begin
                                // zero-size sentinel at unit 0, linked to itself
                                hdr_wr.link_we = 1'b1;
                                hdr_wr.size_we = 1'b1;
                                rover_next     = '0;
                                started_next   = 1'b1;
                            end
                            state_next = ST_RD_ROVER;
                        end
                    end
                    else
                    begin
                        alloc_mode_next = 1'b0;
                        if ((req.free_address != '0) && started_reg)
                        begin
                            hdr_next     = req.free_address - LINK_W'(1);
                            p_next       = rover_reg;
                            i_steps_next = '0;
                            rd_idx       = rover_reg;
                            state_next   = ST_I_CHK;
                        end
                        else
                        begin
                            res_addr_next   = '0;
                            res_status_next = STAT_OK;
                            state_next      = ST_OUT;
                        end
                    end
                end
            end

            ST_RD_ROVER:
            begin
                rd_idx     = rover_reg;
                state_next = ST_A_FIRST;
            end

            ST_A_FIRST:
            begin
                prev_next  = rover_reg;
                p_next     = rd_hdr.link;
                rd_idx     = rd_hdr.link;
                state_next = ST_A_CHK;
            end

            ST_A_CHK:
            begin
                if (a_steps_reg > STEP_W'(WALK_CAP))
                begin
                    res_addr_next   = '0;
                    res_status_next = STAT_FAIL;
                    state_next      = ST_OUT;
                end
                else
                begin
                    a_steps_next = a_steps_reg + STEP_W'(1);
                    if (rd_hdr.size >= {1'b0, need_reg})
                    begin
                        rover_next = prev_reg;
                        if (rd_hdr.size == {1'b0, need_reg})
                        begin
                            // exact fit: unlink p
                            hdr_wr.link_we  = 1'b1;
                            hdr_wr.idx      = prev_reg;
                            hdr_wr.link     = rd_hdr.link;
                            res_addr_next   = fit_addr;
                            res_status_next = (fit_addr == '0) ? STAT_FAIL : STAT_OK;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            // shrink p, block comes from its tail
                            hdr_wr.size_we = 1'b1;
                            hdr_wr.idx     = p_reg;
                            hdr_wr.size    = rd_hdr.size - {1'b0, need_reg};
                            rest_next      = rd_hdr.size - {1'b0, need_reg};
                            state_next     = ST_A_CARVE;
                        end
                    end
                    else if (p_reg == rover_reg)
                    begin
                        // wrapped without a fit
                        grow_next  = (grow_min_reg < {1'b0, need_reg}) ?
                                     {1'b0, need_reg} : grow_min_reg;
                        state_next = ST_A_GROW;
                    end
                    else
                    begin
                        prev_next = p_reg;
                        p_next    = rd_hdr.link;
                        rd_idx    = rd_hdr.link;
                    end
                end
            end

            ST_A_CARVE:
            begin
                hdr_wr.size_we  = 1'b1;
                hdr_wr.idx      = carve_p;
                hdr_wr.size     = {1'b0, need_reg};
                res_addr_next   = carve_addr;
                res_status_next = (carve_addr == '0) ? STAT_FAIL : STAT_OK;
                state_next      = ST_OUT;
            end

            ST_A_GROW:
            begin
                if (grow_sum > {1'b0, limit_now})
                begin
                    res_addr_next   = '0;
                    res_status_next = STAT_FAIL;
                    state_next      = ST_OUT;
                end
                else
                begin
                    // new region at the old break is freed into the list
                    break_next     = grow_sum[SIZE_W-1:0];
                    hdr_wr.size_we = 1'b1;
                    hdr_wr.idx     = break_reg[LINK_W-1:0];
                    hdr_wr.size    = grow_reg;
                    hdr_next       = break_reg[LINK_W-1:0];
                    p_next         = rover_reg;
                    i_steps_next   = '0;
                    rd_idx         = rover_reg;
                    state_next     = ST_I_CHK;
                end
            end

            ST_I_CHK:
            begin
                if (i_steps_reg > STEP_W'(WALK_CAP))
                begin
                    res_addr_next   = '0;
                    res_status_next = STAT_FAIL;
                    state_next      = ST_OUT;
                end
                else
                begin
                    i_steps_next = i_steps_reg + STEP_W'(1);
                    if (ins_found)
                    begin
                        q_next     = rd_hdr.link;
                        rd_idx     = hdr_reg;
                        state_next = ST_I_HDR;
                    end
                    else
                    begin
                        p_next = rd_hdr.link;
                        rd_idx = rd_hdr.link;
                    end
                end
            end

            ST_I_HDR:
            begin
                sh_next = rd_hdr.size;
                if (({2'b00, hdr_reg} + {1'b0, rd_hdr.size}) == {2'b00, q_reg})
                begin
                    rd_idx     = q_reg;
                    state_next = ST_I_NEXT;
                end
                else
                begin
                    hdr_wr.link_we = 1'b1;
                    hdr_wr.idx     = hdr_reg;
                    hdr_wr.link    = q_reg;
                    rd_idx         = p_reg;
                    state_next     = ST_I_PDAT;
                end
            end

            ST_I_NEXT:
            begin
                hdr_wr.link_we = 1'b1;
                hdr_wr.size_we = 1'b1;
                hdr_wr.idx     = hdr_reg;
                hdr_wr.link    = rd_hdr.link;
                hdr_wr.size    = sh_reg + rd_hdr.size;
                rd_idx         = p_reg;
                state_next     = ST_I_PDAT;
            end

            ST_I_PDAT:
            begin
                // re-read hdr so merges and dropped writes are seen as stored
                sp_next    = rd_hdr.size;
                rd_idx     = hdr_reg;
                state_next = ST_I_LINK;
            end

            ST_I_LINK:
            begin
                hdr_wr.link_we = 1'b1;
                hdr_wr.idx     = p_reg;
                if (({2'b00, p_reg} + {1'b0, sp_reg}) == {2'b00, hdr_reg})
                begin
                    hdr_wr.size_we = 1'b1;
                    hdr_wr.link    = rd_hdr.link;
                    hdr_wr.size    = sp_reg + rd_hdr.size;
                end
                else
                begin
                    hdr_wr.link = hdr_reg;
                end
                rover_next = p_reg;
                if (alloc_mode_reg)
                begin
                    state_next = ST_RD_ROVER;
                end
                else
                begin
                    res_addr_next   = '0;
                    res_status_next = STAT_OK;
                    state_next      = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = res_addr_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rover_reg     <= '0;
            started_reg   <= 1'b0;
            break_reg     <= SIZE_W'(1);
            limit_reg     <= HEAP_LIMIT_RESET;
            grow_min_reg  <= GROW_MIN_RESET;
            a_steps_reg   <= '0;
            i_steps_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            started_reg   <= started_next;
            break_reg     <= break_next;
            limit_reg     <= limit_next;
            grow_min_reg  <= grow_min_next;
            a_steps_reg   <= a_steps_next;
            i_steps_reg   <= i_steps_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        prev_reg       <= prev_next;
        hdr_reg        <= hdr_next;
        q_reg          <= q_next;
        need_reg       <= need_next;
        grow_reg       <= grow_next;
        sh_reg         <= sh_next;
        sp_reg         <= sp_next;
        rest_reg       <= rest_next;
        alloc_mode_reg <= alloc_mode_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

`ifndef SYNTHESIS
    // A taken request always starts work
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg != ST_IDLE))
        else $error("request transfer did not leave idle");

    // The break never passes the usable heap
    a_break_bound: assert property (@(posedge clk) disable iff (!rst_n)
        break_reg <= LIMIT_CAP)
        else $error("break past heap limit");

    // Rover stays on the sentinel until the list exists
    a_rover_unstarted: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (rover_reg == '0))
        else $error("rover moved before first allocate");

    // A nonzero block address is always a success
    a_addr_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_addr_reg != '0)) |-> (rsp_status_reg == STAT_OK))
        else $error("nonzero address with fail status");

    // Carve only follows a fit test
    a_carve_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_CARVE) |-> $past(state_reg == ST_A_CHK))
        else $error("carve without fit test");

    // Walk counters stop one past the cap
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (a_steps_reg <= STEP_W'(WALK_CAP + 1)) && (i_steps_reg <= STEP_W'(WALK_CAP + 1)))
        else $error("walk counter overran");
`endif

endmodule

`default_nettype wire

// File: sv/fla_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read
module fla_ram
    import fla_pkg::*;
#(
    parameter int WIDTH = LINK_W,
    parameter int DEPTH = HEAP_UNITS_DEFAULT,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/fla_hdr_store.sv
`default_nettype none

// Header store: link and size kept in separate RAMs so either can be
// written alone. Indexes past the physical depth read zero, writes drop.
module fla_hdr_store
    import fla_pkg::*;
#(
    parameter int unsigned HEAP_UNITS = HEAP_UNITS_DEFAULT
)
(
    input  logic              clk,
    input  logic [LINK_W-1:0] rd_idx,
    input  hdr_wr_t           wr,
    output hdr_t              rd_hdr
);

    localparam int unsigned MEM_DEPTH = (HEAP_UNITS < 65536) ? HEAP_UNITS : 65536;
    localparam int AW = $clog2(MEM_DEPTH);

    logic              rd_ok;
    logic              wr_ok;
    logic              rd_ok_reg;
    logic [LINK_W-1:0] link_q;
    logic [SIZE_W-1:0] size_q;

    assign rd_ok = ({1'b0, rd_idx} < SIZE_W'(MEM_DEPTH));
    assign wr_ok = ({1'b0, wr.idx} < SIZE_W'(MEM_DEPTH));

    always_ff @(posedge clk)
    begin
        rd_ok_reg <= rd_ok;
    end

    fla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MEM_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (wr.link_we && wr_ok),
        .waddr (wr.idx[AW-1:0]),
        .wdata (wr.link),
        .raddr (rd_idx[AW-1:0]),
        .rdata (link_q)
    );

    fla_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MEM_DEPTH)
    ) u_size_ram (
        .clk   (clk),
        .we    (wr.size_we && wr_ok),
        .waddr (wr.idx[AW-1:0]),
        .wdata (wr.size),
        .raddr (rd_idx[AW-1:0]),
        .rdata (size_q)
    );

    assign rd_hdr = rd_ok_reg ? hdr_t'{link: link_q, size: size_q} : '0;

endmodule

`default_nettype wire
